FILE: sv/sfla_pkg.sv
// Shared constants for the sorted free-list handle allocator.
// Command, status and register codes, field widths and parameter defaults.
// No dependencies.
package sfla_pkg;

    // Parameter defaults
    localparam int DEF_SLOT_DEPTH  = 1024;
    localparam int DEF_HANDLE_BITS = 32;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int COUNT_W    = 11;
    localparam int RANGE_W    = 11;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Commands (s_tuser)
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    // Result status (m_tuser)
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_BASE     = 2'd0;
    localparam logic [1:0] REG_RANGE    = 2'd1;
    localparam logic [1:0] REG_ALL_USED = 2'd2;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] RESET_BASE  = 32'd1;
    localparam logic [RANGE_W-1:0]    RESET_RANGE = 11'd1024;

endpackage

FILE: sv/sfla_cfg.sv
// Configuration registers of the handle allocator, APB write and read.
// Also derives the number of managed slots (range clipped to the depth).
// Depends on sfla_pkg.
module sfla_cfg #(
    parameter int SLOT_DEPTH = sfla_pkg::DEF_SLOT_DEPTH,
    parameter int IW         = $clog2(SLOT_DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sfla_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [sfla_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [sfla_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [sfla_pkg::CFG_DATA_W-1:0]   base_handle,
    output logic [IW-1:0]                     managed,
    output logic                              start_all_used
);

    logic [sfla_pkg::CFG_DATA_W-1:0] base_reg;
    logic [sfla_pkg::RANGE_W-1:0]    range_reg;
    logic                            all_used_reg;
    logic                            wr_en;
    logic [1:0]                      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= sfla_pkg::RESET_BASE;
            range_reg    <= sfla_pkg::RESET_RANGE;
            all_used_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                sfla_pkg::REG_BASE:     base_reg     <= pwdata;
                sfla_pkg::REG_RANGE:    range_reg    <= pwdata[sfla_pkg::RANGE_W-1:0];
                sfla_pkg::REG_ALL_USED: all_used_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            sfla_pkg::REG_BASE:     prdata = base_reg;
            sfla_pkg::REG_RANGE:    prdata = 32'(range_reg);
            sfla_pkg::REG_ALL_USED: prdata = 32'(all_used_reg);
            default:                prdata = '0;
        endcase
    end

    // range saturates at the depth
    assign managed = (32'(range_reg) > 32'(SLOT_DEPTH)) ? IW'(SLOT_DEPTH) : IW'(range_reg);
    assign base_handle    = base_reg;
    assign start_all_used = all_used_reg;

endmodule

FILE: sv/sorted_free_list_handle_allocator.sv
// Top level of the sorted free-list handle allocator: command sequencer and link memory.
// Depends on sfla_pkg and sfla_cfg.
//
// Hands out handles base_handle + slot from a list of free slots kept sorted by slot index.
// Each input word (tuser = command, tdata = handle) yields exactly one output word. State
// lives in one synchronous RAM of SLOT_DEPTH entries, each {free flag, link to next free
// slot}, read through an output register. One command is in flight at a time; the next word
// is taken once the result is in the output register, which may still be waiting.
// Allocate pops the head of the list, or reports no free slot. Free checks the range and the
// used count, then reads the slot and rejects it if already free; else it walks the sorted
// list (from the last freed slot when that lies below, else from the head) and links the
// slot in, rewriting the previous entry unless it goes in at the head. Init rebuilds the
// list by a one-entry-a-cycle RAM sweep. After reset the RAM is cleared by the same sweep,
// with s_tready low. Configuration may be written only while no command is in progress.
module sorted_free_list_handle_allocator #(
    parameter int SLOT_DEPTH  = sfla_pkg::DEF_SLOT_DEPTH,
    parameter int HANDLE_BITS = sfla_pkg::DEF_HANDLE_BITS,
    localparam int S_DATA_W   = ((HANDLE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((HANDLE_BITS + 1 + sfla_pkg::COUNT_W + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_DATA_W-1:0]              s_tdata,   // [HANDLE_BITS-1:0] handle, zero pad
    input  logic [sfla_pkg::CMD_W-1:0]       s_tuser,   // [1:0] cmd
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [M_DATA_W-1:0]              m_tdata,   // result_handle, used_count(11),
                                                        // is_full(1), zero pad
    output logic [sfla_pkg::STAT_W-1:0]      m_tuser,   // [1:0] status
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfla_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [sfla_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [sfla_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int AW = $clog2(SLOT_DEPTH);       // RAM address
    localparam int IW = $clog2(SLOT_DEPTH + 1);   // slot index plus "none"
    localparam int CW = (HANDLE_BITS > IW) ? HANDLE_BITS : IW;
    localparam logic [IW-1:0] NIL    = IW'(SLOT_DEPTH);
    localparam logic [AW-1:0] LAST_A = AW'(SLOT_DEPTH - 1);

    // sequencer states
    localparam logic [3:0] ST_SWEEP     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_DISP      = 4'd2;
    localparam logic [3:0] ST_ALLOC     = 4'd3;
    localparam logic [3:0] ST_FCHK      = 4'd4;
    localparam logic [3:0] ST_WALK      = 4'd5;
    localparam logic [3:0] ST_WWAIT     = 4'd6;
    localparam logic [3:0] ST_LINK_IDX  = 4'd7;
    localparam logic [3:0] ST_LINK_PREV = 4'd8;
    localparam logic [3:0] ST_RESP      = 4'd9;

    // configuration
    logic [sfla_pkg::CFG_DATA_W-1:0] base_handle;
    logic [IW-1:0]                   managed;
    logic                            start_all_used;

    sfla_cfg #(
        .SLOT_DEPTH (SLOT_DEPTH),
        .IW         (IW)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .base_handle    (base_handle),
        .managed        (managed),
        .start_all_used (start_all_used)
    );

    // link RAM: bit IW = slot free, [IW-1:0] = next free slot
    logic [IW:0]   ram [SLOT_DEPTH];
    logic [IW:0]   rdata_reg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [IW:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram[ram_waddr] <= ram_wdata;
        end
        if (ram_re)
        begin
            rdata_reg <= ram[ram_raddr];
        end
    end

    // control state
    logic [3:0]       state_reg, state_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic             fill_reg, fill_next;
    logic             sweep_reply_reg, sweep_reply_next;
    logic [IW-1:0]    head_reg, head_next;
    logic [IW-1:0]    hint_reg, hint_next;
    logic [IW-1:0]    in_use_reg, in_use_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [sfla_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [HANDLE_BITS-1:0]      hdl_reg, hdl_next;
    logic [IW-1:0]               idx_reg, idx_next;
    logic [IW-1:0]               cur_reg, cur_next;
    logic [IW-1:0]               prev_reg, prev_next;
    logic [HANDLE_BITS-1:0]      res_handle_reg, res_handle_next;
    logic [sfla_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [M_DATA_W-1:0]         out_data_reg, out_data_next;
    logic [sfla_pkg::STAT_W-1:0] out_user_reg, out_user_next;

    // datapath helpers
    logic [HANDLE_BITS-1:0] base_ext;
    logic [HANDLE_BITS-1:0] off;
    logic                   off_ok;
    logic [IW-1:0]          rd_link;
    logic [IW-1:0]          rd_link_ok;
    logic [IW-1:0]          sw_idx;
    logic [IW-1:0]          sw_nxt;
    logic                   is_full;

    assign base_ext   = HANDLE_BITS'(base_handle);
    assign off        = hdl_reg - base_ext;
    assign off_ok     = CW'(off) < CW'(managed);
    assign rd_link    = rdata_reg[IW-1:0];
    assign rd_link_ok = (rd_link < NIL) ? rd_link : NIL;
    assign sw_idx     = IW'(cnt_reg);
    assign sw_nxt     = sw_idx + IW'(1);
    assign is_full    = in_use_reg >= managed;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        fill_next        = fill_reg;
        sweep_reply_next = sweep_reply_reg;
        head_next        = head_reg;
        hint_next        = hint_reg;
        in_use_next      = in_use_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        cmd_next         = cmd_reg;
        hdl_next         = hdl_reg;
        idx_next         = idx_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        res_handle_next  = res_handle_reg;
        res_status_next  = res_status_reg;
        out_data_next    = out_data_reg;
        out_user_next    = out_user_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                // rebuild one entry per cycle; list 0 -> 1 -> ... -> managed-1, flagged free only when filling
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = {fill_reg && (sw_idx < managed), (sw_nxt < managed) ? sw_nxt : NIL};
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LAST_A)
                begin
                    state_next = sweep_reply_reg ? ST_RESP : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    hdl_next   = s_tdata[HANDLE_BITS-1:0];
                    state_next = ST_DISP;
                end
            end

            ST_DISP:
            begin
                res_handle_next = '0;
                res_status_next = sfla_pkg::STAT_OK;
                unique case (cmd_reg)
                    sfla_pkg::CMD_ALLOC:
                    begin
                        if (head_reg < NIL)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(head_reg);
                            state_next = ST_ALLOC;
                        end
                        else
                        begin
                            res_status_next = sfla_pkg::STAT_NO_FREE;
                            state_next      = ST_RESP;
                        end
                    end
                    sfla_pkg::CMD_FREE:
                    begin
                        if (off_ok && (in_use_reg != '0))
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(off);
                            idx_next   = IW'(off);
                            state_next = ST_FCHK;
                        end
                        else
                        begin
                            res_status_next = sfla_pkg::STAT_INVALID;
                            state_next      = ST_RESP;
                        end
                    end
                    sfla_pkg::CMD_INIT:
                    begin
                        fill_next        = !start_all_used && (managed != '0);
                        in_use_next      = start_all_used ? managed : '0;
                        head_next        = (!start_all_used && (managed != '0)) ? '0 : NIL;
                        hint_next        = NIL;
                        cnt_next         = '0;
                        sweep_reply_next = 1'b1;
                        state_next       = ST_SWEEP;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_ALLOC:
            begin
                // pop head: clear its free flag, keep its link
                ram_we          = 1'b1;
                ram_waddr       = AW'(head_reg);
                ram_wdata       = {1'b0, rd_link};
                head_next       = rd_link_ok;
                in_use_next     = in_use_reg + IW'(1);
                res_handle_next = base_ext + HANDLE_BITS'(head_reg);
                if (hint_reg == head_reg)
                begin
                    hint_next = NIL;
                end
                state_next = ST_RESP;
            end

            ST_FCHK:
            begin
                if (rdata_reg[IW])
                begin
                    res_status_next = sfla_pkg::STAT_INVALID;
                    state_next      = ST_RESP;
                end
                else
                begin
                    cur_next   = ((hint_reg < NIL) && (idx_reg > hint_reg)) ? hint_reg : head_reg;
                    prev_next  = NIL;
                    hint_next  = idx_reg;
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                if ((cur_reg < NIL) && (cur_reg < idx_reg))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(cur_reg);
                    prev_next  = cur_reg;
                    state_next = ST_WWAIT;
                end
                else
                begin
                    state_next = ST_LINK_IDX;
                end
            end

            ST_WWAIT:
            begin
                cur_next   = rd_link_ok;
                state_next = ST_WALK;
            end

            ST_LINK_IDX:
            begin
                // cur is the first free slot above idx (or the old head)
                ram_we      = 1'b1;
                ram_waddr   = AW'(idx_reg);
                ram_wdata   = {1'b1, cur_reg};
                in_use_next = in_use_reg - IW'(1);
                if (prev_reg == NIL)
                begin
                    head_next  = idx_reg;
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_LINK_PREV;
                end
            end

            ST_LINK_PREV:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(prev_reg);
                ram_wdata  = {1'b1, idx_reg};
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_data_next    = M_DATA_W'({is_full,
                                                  sfla_pkg::COUNT_W'(in_use_reg),
                                                  res_handle_reg});
                    out_user_next    = res_status_reg;
                    sweep_reply_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            cnt_reg         <= '0;
            fill_reg        <= 1'b0;
            sweep_reply_reg <= 1'b0;
            head_reg        <= NIL;
            hint_reg        <= NIL;
            in_use_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            fill_reg        <= fill_next;
            sweep_reply_reg <= sweep_reply_next;
            head_reg        <= head_next;
            hint_reg        <= hint_next;
            in_use_reg      <= in_use_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        hdl_reg        <= hdl_next;
        idx_reg        <= idx_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        res_handle_reg <= res_handle_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

`ifndef SYNTH
    // a word reporting no free slot never carries a handle
    a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == sfla_pkg::STAT_NO_FREE)) |-> (m_tdata[HANDLE_BITS-1:0] == '0))
        else $error("no-free result carries a nonzero handle");

    // the RAM is never written while the block waits for a command
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != ST_IDLE))
        else $error("link RAM written in idle");

    // the insertion walk only passes slots below the one being freed
    a_walk_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) && (prev_reg != NIL)) |-> (prev_reg < idx_reg))
        else $error("free list walk passed the insertion point");
`endif

endmodule
